// ----- src/esd_pkg.sv -----
// ---------------------------------------------------------------------------
// esd_pkg
// Types and character codes shared by the escape sequence decoder files.
// ---------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HEX2 = 2'd1,
    MODE_HEX4 = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  digits_left;
    logic [15:0] hex_value;
  } dec_state_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       failed;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } res_group_t;

  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_APOS   = 8'h27;
  localparam logic [7:0] CHAR_B      = 8'h62;
  localparam logic [7:0] CHAR_F      = 8'h66;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_R      = 8'h72;
  localparam logic [7:0] CHAR_T      = 8'h74;
  localparam logic [7:0] CHAR_E      = 8'h65;
  localparam logic [7:0] CHAR_X      = 8'h78;
  localparam logic [7:0] CHAR_U      = 8'h75;

  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_ESC = 8'h1B;

  localparam logic [2:0] DIGITS_HEX2 = 3'd2;
  localparam logic [2:0] DIGITS_HEX4 = 3'd4;

endpackage

`default_nettype wire

// ----- src/esd_if.sv -----
// ---------------------------------------------------------------------------
// esd_if
// Valid/ready channels for escape characters and decoded result bytes.
// ---------------------------------------------------------------------------
`default_nettype none

interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] esc_char;
  logic       text_ends;

  modport source (output valid, output esc_char, output text_ends, input ready);
  modport sink   (input valid, input esc_char, input text_ends, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       failed;
  logic       last_of_run;

  modport source (output valid, output out_byte, output failed, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input failed, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ----- src/esd_decode.sv -----
// ---------------------------------------------------------------------------
// esd_decode
// Decodes one escape character against the current state into the next
// state and a group of zero to three result bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module esd_decode (
  input  wire logic [7:0]          esc_char,
  input  wire logic                text_ends,
  input  wire esd_pkg::dec_state_t st,
  output esd_pkg::dec_state_t      st_next,
  output esd_pkg::res_group_t      grp
);

  localparam esd_pkg::dec_state_t STATE_IDLE = '{esd_pkg::MODE_IDLE, 3'd0, 16'd0};

  logic        is_hex;
  logic [3:0]  digit;
  logic [15:0] hex_next;
  logic [2:0]  left_next;

  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    case (esc_char) inside
      [8'h30:8'h39]: digit = 4'(esc_char - 8'h30);
      [8'h61:8'h66]: digit = 4'(esc_char - 8'h57);
      [8'h41:8'h46]: digit = 4'(esc_char - 8'h37);
      default:       is_hex = 1'b0;
    endcase
  end

  assign hex_next  = {st.hex_value[11:0], digit};
  assign left_next = st.digits_left - 3'd1;

  always_comb begin
    st_next    = st;
    grp.cnt    = 2'd0;
    grp.failed = 1'b0;
    grp.b0     = 8'd0;
    grp.b1     = 8'd0;
    grp.b2     = 8'd0;
    if (st.mode != esd_pkg::MODE_HEX2 && st.mode != esd_pkg::MODE_HEX4) begin
      st_next.mode = esd_pkg::MODE_IDLE;
      grp.cnt      = 2'd1;
      case (esc_char)
        esd_pkg::CHAR_DQUOTE: grp.b0 = esd_pkg::CHAR_DQUOTE;
        esd_pkg::CHAR_BSLASH: grp.b0 = esd_pkg::CHAR_BSLASH;
        esd_pkg::CHAR_APOS:   grp.b0 = esd_pkg::CHAR_APOS;
        esd_pkg::CHAR_B:      grp.b0 = esd_pkg::BYTE_BS;
        esd_pkg::CHAR_F:      grp.b0 = esd_pkg::BYTE_FF;
        esd_pkg::CHAR_N:      grp.b0 = esd_pkg::BYTE_LF;
        esd_pkg::CHAR_R:      grp.b0 = esd_pkg::BYTE_CR;
        esd_pkg::CHAR_T:      grp.b0 = esd_pkg::BYTE_TAB;
        esd_pkg::CHAR_E:      grp.b0 = esd_pkg::BYTE_ESC;
        esd_pkg::CHAR_X, esd_pkg::CHAR_U: begin
          if (text_ends) begin
            st_next    = STATE_IDLE;
            grp.failed = 1'b1;
          end else begin
            st_next.mode        = (esc_char == esd_pkg::CHAR_X) ? esd_pkg::MODE_HEX2
                                                                 : esd_pkg::MODE_HEX4;
            st_next.digits_left = (esc_char == esd_pkg::CHAR_X) ? esd_pkg::DIGITS_HEX2
                                                                 : esd_pkg::DIGITS_HEX4;
            st_next.hex_value   = 16'd0;
            grp.cnt             = 2'd0;
          end
        end
        default: begin
          st_next    = STATE_IDLE;
          grp.failed = 1'b1;
        end
      endcase
    end else if (!is_hex) begin
      st_next    = STATE_IDLE;
      grp.cnt    = 2'd1;
      grp.failed = 1'b1;
    end else if (left_next != 3'd0) begin
      st_next.hex_value   = hex_next;
      st_next.digits_left = left_next;
      if (text_ends) begin
        st_next    = STATE_IDLE;
        grp.cnt    = 2'd1;
        grp.failed = 1'b1;
      end
    end else begin
      st_next = STATE_IDLE;
      if (st.mode == esd_pkg::MODE_HEX2 || hex_next < 16'h0080) begin
        grp.cnt = 2'd1;
        grp.b0  = hex_next[7:0];
      end else if (hex_next < 16'h0800) begin
        grp.cnt = 2'd2;
        grp.b0  = {3'b110, hex_next[10:6]};
        grp.b1  = {2'b10, hex_next[5:0]};
      end else begin
        grp.cnt = 2'd3;
        grp.b0  = {4'b1110, hex_next[15:12]};
        grp.b1  = {2'b10, hex_next[11:6]};
        grp.b2  = {2'b10, hex_next[5:0]};
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/escape_sequence_decoder.sv -----
// ---------------------------------------------------------------------------
// escape_sequence_decoder
// Decodes C-style escape text, one character per transfer, into bytes.
// ---------------------------------------------------------------------------
// A character is registered in the input stage, decoded from there into the
// result register, and its first result byte is offered from there.
// Throughput: one character per cycle while the result register is free;
// a \u escape of two or three UTF-8 bytes holds it until each byte transfers.
// Reset empties the input stage and the result register and idles the decoder.
`default_nettype none

module escape_sequence_decoder (
  input wire logic   clk,
  input wire logic   rst,
  esd_in_if.sink     chars,
  esd_out_if.source  results
);

  logic                in_vld;
  logic [7:0]          in_char;
  logic                in_ends;
  esd_pkg::dec_state_t st;
  esd_pkg::dec_state_t st_next;
  esd_pkg::res_group_t dec_grp;
  logic [1:0]          grp_cnt;
  logic                grp_failed;
  logic [7:0]          grp_b0;
  logic [7:0]          grp_b1;
  logic [7:0]          grp_b2;
  logic                pop;
  logic                grp_free;
  logic                advance;

  esd_decode u_decode (
    .esc_char  (in_char),
    .text_ends (in_ends),
    .st        (st),
    .st_next   (st_next),
    .grp       (dec_grp)
  );

  assign pop      = results.valid && results.ready;
  assign grp_free = (grp_cnt == 2'd0) || (grp_cnt == 2'd1 && results.ready);
  assign advance  = in_vld && grp_free;

  assign chars.ready         = !in_vld || grp_free;
  assign results.valid       = grp_cnt != 2'd0;
  assign results.out_byte    = grp_b0;
  assign results.failed      = grp_failed;
  assign results.last_of_run = grp_cnt == 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      grp_cnt <= 2'd0;
      st      <= '{esd_pkg::MODE_IDLE, 3'd0, 16'd0};
    end else begin
      if (chars.ready) begin
        in_vld <= chars.valid;
      end
      if (advance) begin
        grp_cnt <= dec_grp.cnt;
        st      <= st_next;
      end else if (pop) begin
        grp_cnt <= grp_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready) begin
      in_char <= chars.esc_char;
      in_ends <= chars.text_ends;
    end
    if (advance) begin
      grp_failed <= dec_grp.failed;
      grp_b0     <= dec_grp.b0;
      grp_b1     <= dec_grp.b1;
      grp_b2     <= dec_grp.b2;
    end else if (pop) begin
      grp_b0 <= grp_b1;
      grp_b1 <= grp_b2;
    end
  end

endmodule

`default_nettype wire
